### rtl/mri_pkg.sv
`timescale 1ns / 1ps
// Package for the MLP ReLU inference core: sizes, mode codes, helpers.
// No dependencies.
package mri_pkg;
  localparam int N_IN     = 60;
  localparam int N_LAYERS = 5;
  localparam int N_OUT    = 2;

  localparam int IDX_W    = 6;   // neuron / source index width
  localparam int LAY_W    = 3;
  localparam int CNT_W    = 7;
  localparam int ACC_W    = 40;
  localparam int PROD_W   = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int HW_DEPTH = N_LAYERS * N_IN * N_IN;
  localparam int HW_AW    = $clog2(HW_DEPTH);
  localparam int OW_DEPTH = N_OUT * N_IN;
  localparam int OW_AW    = $clog2(OW_DEPTH);
  localparam int NCELL    = N_IN;

  localparam logic [1:0] MODE_HID = 2'd0;
  localparam logic [1:0] MODE_OUT = 2'd1;
  localparam logic [1:0] MODE_SMP = 2'd2;

  typedef logic signed [15:0] word_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // ReLU, Q18.22 -> Q8.8 with saturation
  function automatic word_t relu_q88(input acc_t a);
    acc_t q;
    q = a >>> 14;
    if (a <= 0) return '0;
    if (q > acc_t'(32767)) return 16'sd32767;
    return word_t'(q[15:0]);
  endfunction
endpackage

### rtl/mri_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the inference core.
// Depends on mri_pkg.
interface mri_in_if import mri_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [2:0]       layer;
  logic [5:0]       neuron;
  logic [5:0]       source;
  logic signed [15:0] value;
  logic             last;
  modport source_mp (output valid, mode, layer, neuron, source, value, last, input ready);
  modport sink_mp   (input valid, mode, layer, neuron, source, value, last, output ready);
endinterface

interface mri_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] decisions;
  logic       length_error;
  modport source_mp (output valid, decisions, length_error, input ready);
  modport sink_mp   (input valid, decisions, length_error, output ready);
endinterface

### rtl/mri_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mri_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/mri_cell.sv
`timescale 1ns / 1ps
// One cell of the activation chain: holds one activation and passes it on.
// Depends on mri_pkg.
module mri_cell import mri_pkg::*; (
  input  logic  clk,
  input  logic  load,     // parallel load of a fresh value
  input  word_t load_val,
  input  logic  shift,    // rotate by one position
  input  word_t prev_val, // neighbor's value
  output word_t act
);
  word_t act_r, act_nxt;

  // load, rotate or hold
  always_comb begin
    act_nxt = act_r;
    if (load)       act_nxt = load_val;
    else if (shift) act_nxt = prev_val;
  end

  always_ff @(posedge clk) act_r <= act_nxt;

  assign act = act_r;
endmodule

### rtl/mlp_relu_inference_core.sv
`timescale 1ns / 1ps
// Top level of the MLP ReLU inference core. Depends on mri_pkg, mri_if, mri_ram, mri_cell.
//
// Weight loads and non-last sample elements are accepted while the core is idle.
// A last element starts evaluation: one shared MAC unit runs N_IN products per
// neuron over a rotating chain of N_IN activation cells. Each neuron issues N_IN
// weight reads, one per product; then the read and product pipeline registers
// drain into the accumulator and ST_FIN finishes the neuron. A wrong-length sample
// answers in the next cycle. The result waits in an output register; no input is
// taken during evaluation or while a result waits.
module mlp_relu_inference_core import mri_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  mri_in_if.sink_mp    in_ch,
  mri_out_if.source_mp out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;          // count including the arriving element
  logic [LAY_W:0]   lay_r, lay_nxt;   // N_LAYERS means output layer
  logic [IDX_W-1:0] neu_r, neu_nxt;
  logic [IDX_W:0]   src_r, src_nxt;   // issued read index
  logic             v1_r, v2_r;       // read and product valid
  acc_t             acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [N_OUT-1:0] bits_r, bits_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [1:0]       odec_r, odec_nxt;
  logic             oerr_r, oerr_nxt;

  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !ovalid_r;

  // weight memories
  logic             hw_we, ow_we;
  logic [HW_AW-1:0] hw_wa, hw_ra;
  logic [OW_AW-1:0] ow_wa, ow_ra;
  logic [15:0]      hw_rd, ow_rd;

  assign hw_we = acc_in && in_ch.mode == MODE_HID && in_ch.layer < LAY_W'(N_LAYERS)
                 && in_ch.neuron < IDX_W'(N_IN) && in_ch.source < IDX_W'(N_IN);
  assign ow_we = acc_in && in_ch.mode == MODE_OUT && in_ch.neuron < IDX_W'(N_OUT)
                 && in_ch.source < IDX_W'(N_IN);
  assign hw_wa = HW_AW'((32'(in_ch.layer) * N_IN + 32'(in_ch.neuron)) * N_IN
                 + 32'(in_ch.source));
  assign ow_wa = OW_AW'(32'(in_ch.neuron) * N_IN + 32'(in_ch.source));
  assign hw_ra = HW_AW'((32'(lay_r) * N_IN + 32'(neu_r)) * N_IN + 32'(src_r));
  assign ow_ra = OW_AW'(32'(neu_r) * N_IN + 32'(src_r));

  mri_ram #(.WIDTH(16), .DEPTH(HW_DEPTH)) u_hw (
    .clk, .we(hw_we), .waddr(hw_wa), .wdata(in_ch.value), .raddr(hw_ra), .rdata(hw_rd));
  mri_ram #(.WIDTH(16), .DEPTH(OW_DEPTH)) u_ow (
    .clk, .we(ow_we), .waddr(ow_wa), .wdata(in_ch.value), .raddr(ow_ra), .rdata(ow_rd));

  // activation chain: cell 0 feeds the MAC, rotates toward 0.
  // Samples shift in at the tail; results shift into the next-layer chain's tail during a layer.
  word_t act [NCELL];
  word_t nact [NCELL];   // next-layer chain
  logic  smp_shift, rot, nxt_shift, swap;
  word_t new_act;

  assign smp_shift = acc_in && in_ch.mode == MODE_SMP && cnt_r < CNT_W'(N_IN);
  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      // load the next-layer chain as it stands after its final shift
      mri_cell u_a (
        .clk, .load(swap), .load_val(g == NCELL-1 ? new_act : nact[g+1]),
        .shift(rot || smp_shift),
        .prev_val(g == NCELL-1 ? (smp_shift ? in_ch.value : act[0]) : act[g+1]),
        .act(act[g]));
      mri_cell u_n (
        .clk, .load(1'b0), .load_val(new_act), .shift(nxt_shift),
        .prev_val(g == NCELL-1 ? new_act : nact[g+1]), .act(nact[g]));
    end
  endgenerate
  // sample arrival writes from the tail: after N_IN shifts, element 0 sits at cell 0

  logic [IDX_W-1:0] neu_last;
  logic             out_layer, issue, mac_done;
  word_t            wsel;
  assign out_layer = lay_r == (LAY_W+1)'(N_LAYERS);
  assign neu_last  = out_layer ? IDX_W'(N_OUT-1) : IDX_W'(N_IN-1);
  assign issue     = (st_r == ST_MAC) && src_r < (IDX_W+1)'(N_IN);
  assign rot       = v1_r;            // cell 0 consumed with the weight read
  assign wsel      = out_layer ? word_t'(ow_rd) : word_t'(hw_rd);
  assign new_act   = relu_q88(acc_r);
  assign mac_done  = (st_r == ST_MAC) && !issue && !v1_r && !v2_r;
  assign nxt_shift = (st_r == ST_FIN) && !out_layer;
  assign swap      = (st_r == ST_FIN) && !out_layer && neu_r == neu_last;
  assign cnt_inc   = (cnt_r < COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(act[0]) * PROD_W'(wsel);
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; lay_nxt = lay_r; neu_nxt = neu_r; src_nxt = src_r;
    acc_nxt = acc_r; bits_nxt = bits_r;
    ovalid_nxt = ovalid_r; odec_nxt = odec_r; oerr_nxt = oerr_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    if (v2_r) acc_nxt = acc_r + acc_t'(prod_r);
    if (issue) src_nxt = src_r + 1'b1;
    unique case (st_r)
      ST_IDLE: begin
        if (acc_in && in_ch.mode == MODE_SMP) begin
          cnt_nxt = cnt_inc;
          if (in_ch.last) begin
            cnt_nxt = '0;
            if (cnt_inc != CNT_W'(N_IN)) begin
              ovalid_nxt = 1'b1; odec_nxt = '0; oerr_nxt = 1'b1;
            end else begin
              st_nxt = ST_MAC; lay_nxt = '0; neu_nxt = '0; src_nxt = '0;
              acc_nxt = '0; bits_nxt = '0;
            end
          end
        end
      end
      ST_MAC: if (mac_done) st_nxt = ST_FIN;
      ST_FIN: begin
        if (out_layer) bits_nxt[neu_r[0]] = acc_r > 0;
        acc_nxt = '0; src_nxt = '0;
        if (neu_r == neu_last) begin
          neu_nxt = '0;
          if (out_layer) st_nxt = ST_OUT;
          else begin lay_nxt = lay_r + 1'b1; st_nxt = ST_MAC; end
        end else begin
          neu_nxt = neu_r + 1'b1; st_nxt = ST_MAC;
        end
      end
      ST_OUT: begin
        ovalid_nxt = 1'b1; odec_nxt = 2'(bits_nxt); oerr_nxt = 1'b0; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; lay_r <= '0; neu_r <= '0; src_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; acc_r <= '0; bits_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; lay_r <= lay_nxt; neu_r <= neu_nxt;
      src_r <= src_nxt; v1_r <= issue; v2_r <= v1_r; acc_r <= acc_nxt;
      bits_r <= bits_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odec_r <= odec_nxt; oerr_r <= oerr_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.decisions    = odec_r;
  assign out_ch.length_error = oerr_r;
endmodule

### bench/mlp_relu_inference_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for mlp_relu_inference_core: weight loads, samples, decisions.
// Depends on mri_pkg, mri_in_if, mri_out_if and the core itself.
module mlp_relu_inference_core_test;
  import mri_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 400;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [1:0] mode;
    logic [2:0] layer;
    logic [5:0] neuron;
    logic [5:0] source;
    word_t      value;
    logic       last;
  } request_t;

  typedef struct {
    logic [1:0] decisions;
    logic       length_error;
  } verdict_t;

  // Mirror of the network state; predicts one verdict per last element.
  class network_scoreboard;
    word_t      hid_w[HW_DEPTH];
    word_t      out_w[OW_DEPTH];
    word_t      sample[N_IN];
    int         elem_count;
    verdict_t   pending[$];
    int         errors;
    int         results;
    int         evals;

    function new();
      foreach (hid_w[i]) hid_w[i] = '0;
      foreach (out_w[i]) out_w[i] = '0;
      foreach (sample[i]) sample[i] = '0;
      elem_count = 0;
      errors = 0;
      results = 0;
      evals = 0;
    endfunction

    // Run every hidden layer, then the output neurons; return the decision bits.
    function logic [1:0] run_network();
      word_t      prev[N_IN];
      word_t      cur[N_IN];
      longint     acc;
      logic [1:0] bits;
      bits = '0;
      prev = sample;
      for (int l = 0; l < N_LAYERS; l++) begin
        for (int n = 0; n < N_IN; n++) begin
          acc = 0;
          for (int i = 0; i < N_IN; i++)
            acc += longint'(prev[i]) * longint'(hid_w[(l * N_IN + n) * N_IN + i]);
          if (acc <= 0) cur[n] = '0;
          else if ((acc >>> 14) > 32767) cur[n] = 16'sd32767;
          else cur[n] = word_t'(acc >>> 14);
        end
        prev = cur;
      end
      for (int k = 0; k < N_OUT; k++) begin
        acc = 0;
        for (int i = 0; i < N_IN; i++)
          acc += longint'(prev[i]) * longint'(out_w[k * N_IN + i]);
        if (acc > 0) bits[k] = 1'b1;
      end
      return bits;
    endfunction

    // Update state for one accepted request; queue a verdict on last elements.
    function void note_request(request_t r);
      verdict_t v;
      case (r.mode)
        MODE_HID: begin
          if (r.layer < N_LAYERS && r.neuron < N_IN && r.source < N_IN)
            hid_w[(r.layer * N_IN + r.neuron) * N_IN + r.source] = r.value;
        end
        MODE_OUT: begin
          if (r.neuron < N_OUT && r.source < N_IN)
            out_w[r.neuron * N_IN + r.source] = r.value;
        end
        MODE_SMP: begin
          if (elem_count < N_IN) sample[elem_count] = r.value;
          if (elem_count < COUNT_MAX) elem_count++;
          if (r.last) begin
            if (elem_count != N_IN) begin
              v.decisions = '0;
              v.length_error = 1'b1;
            end else begin
              v.decisions = run_network();
              v.length_error = 1'b0;
              evals++;
            end
            pending.push_back(v);
            elem_count = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest verdict.
    function void check_result(logic [1:0] dec, logic err);
      verdict_t v;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result decisions=%b length_error=%b", $time, dec, err);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (dec !== v.decisions) begin
        $display("%0t: decisions expected %b actual %b", $time, v.decisions, dec);
        errors++;
      end
      if (err !== v.length_error) begin
        $display("%0t: length_error expected %b actual %b", $time, v.length_error, err);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   sent = 0;
  network_scoreboard sb = new();

  mri_in_if  in_ch ();
  mri_out_if out_ch ();

  mlp_relu_inference_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the result channel at random
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.decisions, out_ch.length_error);
  end

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Drive one request; entered and left at a falling edge.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode   = r.mode;
    in_ch.layer  = r.layer;
    in_ch.neuron = r.neuron;
    in_ch.source = r.source;
    in_ch.value  = r.value;
    in_ch.last   = r.last;
    in_ch.valid  = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_load(logic [1:0] mode, int layer, int neuron, int source, word_t value);
    request_t r;
    r.mode = mode;
    r.layer = layer[2:0];
    r.neuron = neuron[5:0];
    r.source = source[5:0];
    r.value = value;
    r.last = 1'($urandom_range(1));
    send_request(r);
  endtask

  // Send a sample of len elements, last on the final one.
  task automatic send_sample(int len);
    request_t r;
    for (int i = 0; i < len; i++) begin
      r.mode = MODE_SMP;
      r.layer = 3'($urandom);
      r.neuron = 6'($urandom);
      r.source = 6'($urandom);
      r.value = pick_word();
      r.last = (i == len - 1);
      send_request(r);
    end
  endtask

  // Hold the sender until every verdict has come back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int idle, int stall);
    int start;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    start = sent;
    while (sent - start < PHASE_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_sample(N_IN);
        4: begin
          len = $urandom_range(1, 20);
          send_sample(len == N_IN ? len + 1 : len);
        end
        5: begin
          len = $urandom_range(40, 70);
          send_sample(len);
        end
        6: send_load(MODE_NONE, $urandom, $urandom, $urandom, pick_word());
        default: begin
          repeat ($urandom_range(1, 8))
            send_load($urandom_range(1) ? MODE_HID : MODE_OUT, $urandom_range(7),
                      $urandom_range(63), $urandom_range(63), pick_word());
        end
      endcase
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NONE;
    in_ch.layer = '0;
    in_ch.neuron = '0;
    in_ch.source = '0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Ignored requests: unused mode, out-of-range indexes
    send_load(MODE_NONE, 7, 63, 63, 16'sh7fff);
    send_load(MODE_HID, 7, 0, 0, 16'sh8000);
    send_load(MODE_HID, N_LAYERS, 5, 5, 16'sh7fff);
    send_load(MODE_HID, 0, 63, 0, 16'sh7fff);
    send_load(MODE_HID, 0, 0, 63, 16'sh7fff);
    send_load(MODE_OUT, 0, N_OUT, 0, 16'sh7fff);
    send_load(MODE_OUT, 0, 63, 63, 16'sh8000);

    // Fill every weight before the first full-length sample
    for (int l = 0; l < N_LAYERS; l++)
      for (int n = 0; n < N_IN; n++)
        for (int s = 0; s < N_IN; s++)
          send_load(MODE_HID, l, n, s, pick_word());
    for (int k = 0; k < N_OUT; k++)
      for (int s = 0; s < N_IN; s++)
        send_load(MODE_OUT, 0, k, s, pick_word());

    // Length cases: one element, short, exact, long, count saturation
    send_sample(1);
    send_sample(N_IN - 1);
    send_sample(N_IN);
    send_sample(N_IN + 1);
    send_sample(130);
    send_sample(N_IN);
    drain();

    random_phase(0, 0);
    random_phase(81, 0);
    random_phase(0, 81);
    random_phase(37, 37);

    $display("Sent %0d requests; %0d results checked, %0d full network evaluations.",
             sent, sb.results, sb.evals);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
